>>> rtl/protobuf_field_decoder_core_defines.svh
// Assertion macros for the protobuf field decoder
`ifndef PROTOBUF_FIELD_DECODER_CORE_DEFINES_SVH
`define PROTOBUF_FIELD_DECODER_CORE_DEFINES_SVH
// implication checked every clock outside reset
`define PFD_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("pfd check failed");
// next-cycle implication
`define PFD_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("pfd check failed");
`endif

>>> rtl/pfd_pkg.sv
// Shared types and constants for the protobuf field decoder
`default_nettype none
package pfd_pkg;
    localparam int unsigned MaxVarintBytesDef = 10;
    localparam int unsigned LengthBitsDef     = 32;
    localparam int unsigned InTdataW  = 56;
    localparam int unsigned OutTdataW = 136;

    localparam logic [2:0] ModeBool  = 3'd0;
    localparam logic [2:0] ModeUint  = 3'd1;
    localparam logic [2:0] ModeZig   = 3'd2;
    localparam logic [2:0] ModeFix32 = 3'd3;
    localparam logic [2:0] ModeFix64 = 3'd4;
    localparam logic [2:0] ModeLen   = 3'd5;

    localparam logic [1:0] ErrNone    = 2'd0;
    localparam logic [1:0] ErrVarint  = 2'd1;
    localparam logic [1:0] ErrLength  = 2'd2;

    // one result as carried through the queue
    typedef struct packed {
        logic        kind;
        logic [28:0] field_number;
        logic [2:0]  wire_kind;
        logic        id_mismatch;
        logic        kind_mismatch;
        logic [63:0] value;
        logic        last;
        logic [31:0] total;
        logic [1:0]  err;
    } t_result;

    function automatic logic [2:0] mode_wire(input logic [2:0] m);
        logic [2:0] w;
        case (m)
            ModeFix32: w = 3'd5;
            ModeFix64: w = 3'd1;
            ModeLen:   w = 3'd2;
            default:   w = 3'd0;
        endcase
        return w;
    endfunction

    function automatic logic [63:0] width_mask(input logic [1:0] w);
        logic [63:0] m;
        case (w)
            2'd0:    m = 64'h0000_0000_0000_00ff;
            2'd1:    m = 64'h0000_0000_0000_ffff;
            2'd2:    m = 64'h0000_0000_ffff_ffff;
            default: m = '1;
        endcase
        return m;
    endfunction
endpackage
`default_nettype wire

>>> rtl/pfd_front.sv
// Front end: byte parser that turns stream bytes into raw results
`default_nettype none
module pfd_front #(
    parameter int unsigned MAX_VARINT_BYTES = pfd_pkg::MaxVarintBytesDef,
    parameter int unsigned LENGTH_BITS      = pfd_pkg::LengthBitsDef
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [7:0]        i_byte,
    input  wire logic [28:0]       i_long_id,
    input  wire logic [7:0]        i_short_id,
    input  wire logic [2:0]        i_mode,
    input  wire logic [1:0]        i_width,
    input  wire logic              i_q_ready,
    output logic                   o_q_valid,
    output pfd_pkg::t_result       o_q_data
);
    import pfd_pkg::*;

    typedef enum logic [2:0] {
        PH_KEY, PH_VARINT, PH_FIXED, PH_LEN, PH_PAYLOAD
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [63:0] r_acc, n_acc;
    logic [3:0]  r_cnt, n_cnt;
    logic [28:0] r_fnum, n_fnum;
    logic [2:0]  r_wk, n_wk;
    logic [2:0]  r_mode, n_mode;
    logic [1:0]  r_width, n_width;
    logic [28:0] r_exp, n_exp;
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_total, n_total;

    logic        fire, emit;
    t_result     res;
    logic [63:0] ored, mask, v, zz;
    logic [4:0]  cnt1;
    logic        first, cont;
    logic [2:0]  modec;
    logic [31:0] tot0;
    logic [63:0] len_lim;

    assign o_ready = i_q_ready;
    assign fire    = i_valid && o_ready;
    assign len_lim = (LENGTH_BITS >= 64) ? '1 : ((64'd1 << LENGTH_BITS) - 64'd1);

    always_comb begin
        n_phase = r_phase; n_acc = r_acc; n_cnt = r_cnt; n_fnum = r_fnum;
        n_wk = r_wk; n_mode = r_mode; n_width = r_width; n_exp = r_exp;
        n_rem = r_rem; n_total = r_total;
        emit = 1'b0; res = '0;
        cont  = i_byte[7];
        cnt1  = {1'b0, r_cnt} + 5'd1;
        first = (r_phase == PH_KEY) && (r_cnt == 4'd0);
        modec = (i_mode > ModeLen) ? ModeUint : i_mode;
        ored  = '0; mask = '0; v = '0; zz = '0;
        if (first) begin
            n_exp   = (i_short_id != 8'd0) ? {21'd0, i_short_id} : i_long_id;
            n_mode  = modec;
            n_width = i_width;
        end
        tot0 = first ? 32'd0 : r_total;
        n_total = (tot0 != '1) ? tot0 + 32'd1 : tot0;
        res.total = n_total;
        res.field_number  = r_fnum;
        res.wire_kind     = r_wk;
        res.id_mismatch   = (r_fnum != n_exp);
        res.kind_mismatch = (r_wk != mode_wire(n_mode));
        res.last = 1'b1;
        case (r_phase)
            PH_KEY, PH_VARINT, PH_LEN: begin
                ored = r_acc;
                if (r_cnt < 4'd10)
                    ored = r_acc | ({57'd0, i_byte[6:0]} << (7 * r_cnt));
                n_acc = ored;
                if (cont) begin
                    if (cnt1 >= 5'(MAX_VARINT_BYTES)) begin
                        emit = 1'b1; res.err = ErrVarint; res.value = '0;
                        if (r_phase == PH_KEY) begin
                            res.field_number = '0; res.wire_kind = '0;
                            res.id_mismatch = 1'b0; res.kind_mismatch = 1'b0;
                        end
                        n_phase = PH_KEY; n_acc = '0; n_cnt = '0;
                    end else begin
                        n_cnt = cnt1[3:0];
                    end
                end else if (r_phase == PH_KEY) begin
                    n_fnum = ored[31:3]; n_wk = ored[2:0];
                    n_acc = '0; n_cnt = '0;
                    if (n_mode == ModeFix32 || n_mode == ModeFix64) n_phase = PH_FIXED;
                    else if (n_mode == ModeLen) n_phase = PH_LEN;
                    else n_phase = PH_VARINT;
                end else if (r_phase == PH_VARINT) begin
                    emit = 1'b1;
                    mask = width_mask(r_width);
                    v = ored & mask;
                    zz = ((v >> 1) ^ (64'd0 - {63'd0, v[0]})) & mask;
                    if ((zz & ((mask >> 1) + 64'd1)) != 64'd0) zz = zz | ~mask;
                    case (r_mode)
                        ModeBool: res.value = {63'd0, ored != 64'd0};
                        ModeZig:  res.value = zz;
                        default:  res.value = v;
                    endcase
                    n_phase = PH_KEY; n_acc = '0; n_cnt = '0;
                end else begin
                    emit = 1'b1;
                    if (ored > len_lim) begin
                        res.err = ErrLength; res.value = '0;
                        n_phase = PH_KEY;
                    end else begin
                        res.value = ored;
                        res.last  = (ored == 64'd0);
                        n_phase   = (ored == 64'd0) ? PH_KEY : PH_PAYLOAD;
                        n_rem     = ored[31:0];
                    end
                    n_acc = '0; n_cnt = '0;
                end
            end
            PH_FIXED: begin
                ored = r_acc;
                if (r_cnt < 4'd8) ored = r_acc | ({56'd0, i_byte} << (8 * r_cnt));
                n_acc = ored;
                if (cnt1 >= ((r_mode == ModeFix32) ? 5'd4 : 5'd8)) begin
                    emit = 1'b1; res.value = ored;
                    n_phase = PH_KEY; n_acc = '0; n_cnt = '0;
                end else begin
                    n_cnt = cnt1[3:0];
                end
            end
            PH_PAYLOAD: begin
                n_rem = (r_rem != 32'd0) ? r_rem - 32'd1 : r_rem;
                emit = 1'b1; res.kind = 1'b1;
                res.value = {56'd0, i_byte};
                res.last = (n_rem == 32'd0);
                if (n_rem == 32'd0) begin
                    n_phase = PH_KEY; n_acc = '0; n_cnt = '0;
                end
            end
            default: begin
                n_phase = PH_KEY; n_acc = '0; n_cnt = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_KEY; r_acc <= '0; r_cnt <= '0; r_fnum <= '0; r_wk <= '0;
            r_mode <= '0; r_width <= '0; r_exp <= '0; r_rem <= '0; r_total <= '0;
        end else if (fire) begin
            r_phase <= n_phase; r_acc <= n_acc; r_cnt <= n_cnt; r_fnum <= n_fnum;
            r_wk <= n_wk; r_mode <= n_mode; r_width <= n_width; r_exp <= n_exp;
            r_rem <= n_rem; r_total <= n_total;
        end
    end

    assign o_q_valid = fire && emit;
    assign o_q_data  = res;
endmodule
`default_nettype wire

>>> rtl/pfd_queue.sv
// Two-entry result queue between parser and output port
`default_nettype none
module pfd_queue (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  pfd_pkg::t_result i_data,
    output logic             o_valid,
    input  wire logic        i_ready,
    output pfd_pkg::t_result o_data
);
    import pfd_pkg::*;

    t_result    r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       wr, rd;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign wr = i_valid && o_ready;
    assign rd = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (wr) r_wp <= ~r_wp;
            if (rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
    end
endmodule
`default_nettype wire

>>> rtl/protobuf_field_decoder_core.sv
// Top level of the protobuf wire-format field decoder
//  channel  dir  tdata fields (low bit first)                      tuser/tlast
//  s_axis   in   data_byte, expected_long_id, expected_short_id,    -
//                decode_mode, value_width (50 bits, 56 wide)
//  m_axis   out  field_number, wire_kind, id_mismatch, kind_mismatch, result_kind/
//                decoded_value, field_byte_total, error_code         last_of_field
// One byte per cycle while the queue is not full; the parser is a single stage feeding a two-entry queue.
// A result is registered in the queue and is available in the cycle after its byte is accepted.
// s_axis_tready drops only while the queue is full.
// Synchronous active-low reset returns the parser to the key phase.
`default_nettype none
`include "protobuf_field_decoder_core_defines.svh"
module protobuf_field_decoder_core #(
    parameter int unsigned MAX_VARINT_BYTES = pfd_pkg::MaxVarintBytesDef,
    parameter int unsigned LENGTH_BITS      = pfd_pkg::LengthBitsDef
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // data_byte, expected_long_id, expected_short_id, decode_mode, value_width
    input  wire logic [pfd_pkg::InTdataW-1:0]    s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // field_number, wire_kind, id_mismatch, kind_mismatch, decoded_value,
    // field_byte_total, error_code
    output logic [pfd_pkg::OutTdataW-1:0]        m_axis_tdata,
    // result_kind
    output logic                                 m_axis_tuser,
    output logic                                 m_axis_tlast
);
    import pfd_pkg::*;

    logic    f_valid, q_ready;
    t_result f_data, q_data;

    pfd_front #(.MAX_VARINT_BYTES(MAX_VARINT_BYTES), .LENGTH_BITS(LENGTH_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_byte(s_axis_tdata[7:0]), .i_long_id(s_axis_tdata[36:8]),
        .i_short_id(s_axis_tdata[44:37]), .i_mode(s_axis_tdata[47:45]),
        .i_width(s_axis_tdata[49:48]),
        .i_q_ready(q_ready), .o_q_valid(f_valid), .o_q_data(f_data)
    );

    pfd_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(f_valid), .o_ready(q_ready), .i_data(f_data),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_data(q_data)
    );

    assign m_axis_tdata = {4'd0, q_data.err, q_data.total, q_data.value,
                           q_data.kind_mismatch, q_data.id_mismatch,
                           q_data.wire_kind, q_data.field_number};
    assign m_axis_tuser = q_data.kind;
    assign m_axis_tlast = q_data.last;

    `PFD_ASSERT_IMP(a_err_last, i_clk, i_rst_n, m_axis_tvalid && q_data.err != ErrNone, m_axis_tlast)
    `PFD_ASSERT_IMP(a_err_kind, i_clk, i_rst_n, m_axis_tvalid && q_data.err != ErrNone, !m_axis_tuser)
    `PFD_ASSERT_NXT(a_push_vis, i_clk, i_rst_n, f_valid && q_ready, m_axis_tvalid)
endmodule
`default_nettype wire
